// ===== design/fat_cluster_chain_walker_top_defines.svh =====
// assertion macros for the fat cluster chain walker
// included by fat_cluster_chain_walker_top.sv, relies on clk and arst_n in scope
`ifndef FAT_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH

// same-cycle implication
`define FCCW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fccw assertion failed");

// next-cycle implication
`define FCCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fccw assertion failed");

`endif

// ===== design/fccw_pkg.sv =====
// package for the fat cluster chain walker: table size, codes, item structs
// no dependencies
`timescale 1ns / 1ps

package fccw_pkg;

	localparam int TABLE_BYTES = 65536;
	localparam int ADDR_W      = $clog2(TABLE_BYTES);
	localparam int BASE_W      = 35;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FAT_TYPE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TOTAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 2'd2;

	localparam logic [2:0] FN_LOAD   = 3'd0;
	localparam logic [2:0] FN_NEXT   = 3'd1;
	localparam logic [2:0] FN_FOLLOW = 3'd2;
	localparam logic [2:0] FN_LENGTH = 3'd3;
	localparam logic [2:0] FN_COUNT  = 3'd4;

	localparam logic [1:0] FT_12 = 2'd0;
	localparam logic [1:0] FT_16 = 2'd1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic [31:0] END12 = 32'h0000_0FF8;
	localparam logic [31:0] END16 = 32'h0000_FFF8;
	localparam logic [31:0] END32 = 32'h0FFF_FFF8;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] byte_index;
		logic [7:0]  byte_value;
		logic [31:0] cluster;
		logic [15:0] steps;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        at_end;
		logic [1:0]  status;
	} rsp_t;

	function automatic logic [31:0] end_marker(input logic [1:0] ft);
		case (ft)
			FT_12:   end_marker = END12;
			FT_16:   end_marker = END16;
			default: end_marker = END32;
		endcase
	endfunction

endpackage

// ===== design/fat_cluster_chain_walker_top.sv =====
// fat cluster chain walker: byte table store, entry reader and walk sequencer
// depends on fccw_pkg and fat_cluster_chain_walker_top_defines.svh
//
//  channel   direction  handshake                       payload
//  request   in         start high while busy low       req (req_t)
//  result    out        done strobe, one cycle          rsp (rsp_t)
//  config    in         cfg_we, cfg_idx                 cfg_wdata
//
// a load answers in the cycle after it is taken; a lookup steps through S_ADDR, S_RANGE, S_READ and S_EVAL
// follow, length and count step through S_TEST and then those states once per link or entry
// entries are read one byte per cycle through the single read port of the table memory
// arst_n resets the sequencer state, the done strobe and the config registers; the table contents are not cleared
// busy is high from the cycle after a multi-cycle item is taken until its result shows
`timescale 1ns / 1ps
`include "fat_cluster_chain_walker_top_defines.svh"

module fat_cluster_chain_walker_top
	import fccw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_ADDR,
		S_RANGE,
		S_READ,
		S_EVAL
	} state_t;

	state_t              state_q;
	logic                done_q;
	rsp_t                rsp_q;
	logic [2:0]          func_q;
	logic [15:0]         steps_q;
	logic [31:0]         cur_q;
	logic [15:0]         n_q;
	logic [BASE_W-1:0]   base_q;
	logic [2:0]          nb_q;
	logic [2:0]          k_q;
	logic [31:0]         ent_q;
	logic [7:0]          rd_data_q;

	logic [1:0]          fat_type_q;
	logic [15:0]         entry_total_q;
	logic [15:0]         step_limit_q;

	logic [7:0]          mem [TABLE_BYTES];

	logic [31:0]         mark;
	logic                cur_at_mark;
	logic                load_ok;
	logic                mem_we;
	logic [ADDR_W-1:0]   rd_addr;
	logic [1:0]          slot;
	logic [31:0]         nx;

	assign mark        = end_marker(fat_type_q);
	assign cur_at_mark = cur_q >= mark;
	assign load_ok     = BASE_W'(req.byte_index) < BASE_W'(TABLE_BYTES);
	assign mem_we      = (state_q == S_IDLE) && start && (req.func == FN_LOAD) && load_ok;
	assign rd_addr     = base_q[ADDR_W-1:0] + ADDR_W'(k_q);
	assign slot        = 2'(k_q - 3'd1);

	always_comb begin
		case (fat_type_q)
			FT_12: begin
				if (cur_q[0])
					nx = {20'd0, ent_q[15:8], ent_q[7:4]};
				else
					nx = {20'd0, ent_q[11:8], ent_q[7:0]};
			end
			FT_16:   nx = {16'd0, ent_q[15:0]};
			default: nx = {4'd0, ent_q[27:0]};
		endcase
	end

	// table store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ADDR_W'(req.byte_index)] <= req.byte_value;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_type_q    <= FT_16;
			entry_total_q <= '0;
			step_limit_q  <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FAT_TYPE:    fat_type_q    <= cfg_wdata[1:0];
				REG_ENTRY_TOTAL: entry_total_q <= cfg_wdata;
				REG_STEP_LIMIT:  step_limit_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= req.func;
						steps_q <= req.steps;
						n_q     <= '0;
						cur_q   <= (req.func == FN_COUNT) ? 32'd0 : req.cluster;
						case (req.func)
							FN_LOAD: begin
								rsp_q  <= '{value: 32'd0, at_end: 1'b0,
									status: load_ok ? ST_OK : ST_RANGE};
								done_q <= 1'b1;
							end
							FN_NEXT: state_q <= S_ADDR;
							FN_FOLLOW, FN_LENGTH, FN_COUNT: state_q <= S_TEST;
							default: begin
								rsp_q  <= '{value: 32'd0, at_end: 1'b0, status: ST_OK};
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_TEST: begin
					case (func_q)
						FN_FOLLOW: begin
							if (!((n_q < steps_q) && !cur_at_mark)) begin
								rsp_q   <= '{value: cur_q, at_end: cur_at_mark, status: ST_OK};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (n_q >= step_limit_q) begin
								rsp_q   <= '{value: cur_q, at_end: 1'b0, status: ST_LIMIT};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ADDR;
							end
						end
						FN_LENGTH: begin
							if (cur_at_mark) begin
								rsp_q   <= '{value: {16'd0, n_q}, at_end: 1'b1, status: ST_OK};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (n_q >= step_limit_q) begin
								rsp_q   <= '{value: {16'd0, n_q}, at_end: 1'b0, status: ST_LIMIT};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ADDR;
							end
						end
						default: begin
							if (cur_q[15:0] >= entry_total_q) begin
								rsp_q   <= '{value: {16'd0, n_q}, at_end: 1'b0, status: ST_OK};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ADDR;
							end
						end
					endcase
				end
				S_ADDR: begin
					case (fat_type_q)
						FT_12: begin
							base_q <= BASE_W'(cur_q) + BASE_W'(cur_q[31:1]);
							nb_q   <= 3'd2;
						end
						FT_16: begin
							base_q <= BASE_W'({cur_q, 1'b0});
							nb_q   <= 3'd2;
						end
						default: begin
							base_q <= BASE_W'({cur_q, 2'b00});
							nb_q   <= 3'd4;
						end
					endcase
					k_q     <= '0;
					state_q <= S_RANGE;
				end
				S_RANGE: begin
					if ((base_q + BASE_W'(nb_q - 3'd1)) < BASE_W'(TABLE_BYTES)) begin
						state_q <= S_READ;
					end else begin
						case (func_q)
							FN_NEXT:   rsp_q <= '{value: 32'd0, at_end: 1'b0, status: ST_RANGE};
							FN_FOLLOW: rsp_q <= '{value: cur_q, at_end: 1'b0, status: ST_RANGE};
							default:   rsp_q <= '{value: {16'd0, n_q}, at_end: 1'b0,
								status: ST_RANGE};
						endcase
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (k_q != 3'd0)
						ent_q[{slot, 3'b000} +: 8] <= rd_data_q;
					if (k_q == nb_q)
						state_q <= S_EVAL;
					else
						k_q <= k_q + 3'd1;
				end
				S_EVAL: begin
					case (func_q)
						FN_NEXT: begin
							rsp_q   <= '{value: nx, at_end: nx >= mark, status: ST_OK};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						FN_COUNT: begin
							if (nx != 32'd0)
								n_q <= n_q + 16'd1;
							cur_q   <= cur_q + 32'd1;
							state_q <= S_TEST;
						end
						default: begin
							cur_q   <= nx;
							n_q     <= n_q + 16'd1;
							state_q <= S_TEST;
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`FCCW_ASSERT_NOW(a_done_when_idle, done_q, state_q == S_IDLE)
	`FCCW_ASSERT_NEXT(a_accept_progress, start && !busy, done_q || busy)
	`FCCW_ASSERT_NOW(a_read_count, state_q == S_READ, k_q <= nb_q)
	`FCCW_ASSERT_NOW(a_error_not_end, done_q && (rsp_q.status != ST_OK), !rsp_q.at_end)

endmodule

// ===== tb/fccw_walk_monitor.sv =====
// result monitor for the fat cluster chain walker: keeps its own table copy and
// register values, works out each accepted item's result and compares the strobed one
// depends on fccw_pkg
`timescale 1ns / 1ps

module fccw_walk_monitor
	import fccw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  req_t                  req,
	input  logic                  done,
	input  rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    pending,
	output int                    errors,
	output int                    checked
);

	logic [7:0]  tbl [0:TABLE_BYTES-1];
	logic [1:0]  fat;
	logic [15:0] entry_cnt;
	logic [15:0] link_limit;
	rsp_t        walk_due [$];
	rsp_t        due;

	function automatic logic read_link(input logic [31:0] c, output logic [31:0] nxt);
		longint unsigned base;
		logic            ok;
		nxt  = '0;
		ok   = 1'b0;
		base = c;
		case (fat)
			FT_12: begin
				base = base * 3 / 2;
				if (base + 1 < TABLE_BYTES) begin
					ok  = 1'b1;
					nxt = c[0] ? {20'h0, tbl[base+1], tbl[base][7:4]}
						: {20'h0, tbl[base+1][3:0], tbl[base]};
				end
			end
			FT_16: begin
				base = base * 2;
				if (base + 1 < TABLE_BYTES) begin
					ok  = 1'b1;
					nxt = {16'h0, tbl[base+1], tbl[base]};
				end
			end
			default: begin
				// reserved top nibble dropped
				base = base * 4;
				if (base + 3 < TABLE_BYTES) begin
					ok  = 1'b1;
					nxt = {4'h0, tbl[base+3][3:0], tbl[base+2], tbl[base+1], tbl[base]};
				end
			end
		endcase
		read_link = ok;
	endfunction

	function automatic rsp_t walk_result(input req_t r);
		rsp_t        o;
		logic [31:0] mark;
		logic [31:0] cur;
		logic [31:0] nxt;
		logic [31:0] i;
		int unsigned n;
		o    = '0;
		mark = (fat == FT_12) ? END12 : (fat == FT_16) ? END16 : END32;
		case (r.func)
			FN_LOAD: begin
				tbl[r.byte_index] = r.byte_value;
			end
			FN_NEXT: begin
				if (read_link(r.cluster, nxt)) begin
					o.value  = nxt;
					o.at_end = (nxt >= mark);
				end else begin
					o.status = ST_RANGE;
				end
			end
			FN_FOLLOW, FN_LENGTH: begin
				cur = r.cluster;
				n   = 0;
				while (cur < mark && (r.func == FN_LENGTH || n < r.steps)) begin
					if (n >= link_limit) begin
						o.status = ST_LIMIT;
						break;
					end
					if (!read_link(cur, nxt)) begin
						o.status = ST_RANGE;
						break;
					end
					cur = nxt;
					n++;
				end
				if (r.func == FN_FOLLOW) begin
					o.value  = cur;
					o.at_end = (o.status == ST_OK && cur >= mark);
				end else begin
					o.value  = n;
					o.at_end = (o.status == ST_OK);
				end
			end
			FN_COUNT: begin
				n = 0;
				for (i = 0; i < entry_cnt; i++) begin
					if (!read_link(i, nxt)) begin
						o.status = ST_RANGE;
						break;
					end
					if (nxt != 0)
						n++;
				end
				o.value = n;
			end
			default: ;
		endcase
		walk_result = o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat        = FT_16;
			entry_cnt  = '0;
			link_limit = '1;
			walk_due.delete();
			pending    = 0;
			errors     = 0;
			checked    = 0;
		end else begin
			if (done) begin
				checked++;
				if (walk_due.size() == 0) begin
					$error("result with no item outstanding: value %h", rsp.value);
					errors++;
				end else begin
					due = walk_due.pop_front();
					if (rsp.value !== due.value) begin
						$error("value: expected %h, got %h", due.value, rsp.value);
						errors++;
					end
					if (rsp.at_end !== due.at_end) begin
						$error("at_end: expected %b, got %b", due.at_end, rsp.at_end);
						errors++;
					end
					if (rsp.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, rsp.status);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_FAT_TYPE:    fat        = cfg_wdata[1:0];
					REG_ENTRY_TOTAL: entry_cnt  = cfg_wdata;
					REG_STEP_LIMIT:  link_limit = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				walk_due.push_back(walk_result(req));
			pending = walk_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// testbench top for the fat cluster chain walker: fills the table, runs directed
// items, then random chains and noise under several register settings
// depends on fccw_pkg, fat_cluster_chain_walker_top and fccw_walk_monitor
`timescale 1ns / 1ps

module tb;
	import fccw_pkg::*;

	localparam logic [2:0]           FN_LAST   = 3'd7;
	localparam logic [1:0]           FT_32     = 2'd2;
	localparam logic [1:0]           FT_ALT    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	req_t                  req       = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;
	int                    pending;
	int                    errors;
	int                    checked;

	int idle_pct = 0;
	int sent     = 0;
	int by_func [0:7];

	always #10 clk = ~clk;

	fat_cluster_chain_walker_top dut (.*);

	fccw_walk_monitor walk_mon (.*);

	function automatic req_t make_req(input logic [2:0] f, input logic [15:0] idx,
		input logic [7:0] val, input logic [31:0] cl, input logic [15:0] st);
		req_t r;
		r.func       = f;
		r.byte_index = idx;
		r.byte_value = val;
		r.cluster    = cl;
		r.steps      = st;
		make_req     = r;
	endfunction

	task automatic send(input req_t item);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		by_func[item.func]++;
	endtask

	task automatic wait_idle;
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [1:0] ft, input logic [15:0] total,
		input logic [15:0] lim);
		logic [15:0] r16;
		wait_idle();
		r16 = $urandom;
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_SPARE;
		cfg_wdata <= r16;
		@(posedge clk);
		cfg_idx   <= REG_FAT_TYPE;
		cfg_wdata <= {r16[15:2], ft};
		@(posedge clk);
		cfg_idx   <= REG_ENTRY_TOTAL;
		cfg_wdata <= total;
		@(posedge clk);
		cfg_idx   <= REG_STEP_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// writes one table entry; shared nibbles and reserved bits get random filler
	task automatic put_entry(input logic [1:0] ft, input logic [31:0] c, input logic [31:0] v);
		logic [31:0] base;
		logic [7:0]  r8;
		r8 = $urandom;
		case (ft)
			FT_12: begin
				base = c + (c >> 1);
				if (c[0]) begin
					send(make_req(FN_LOAD, base[15:0], {v[3:0], r8[3:0]}, '0, '0));
					send(make_req(FN_LOAD, base[15:0] + 16'd1, v[11:4], '0, '0));
				end else begin
					send(make_req(FN_LOAD, base[15:0], v[7:0], '0, '0));
					send(make_req(FN_LOAD, base[15:0] + 16'd1, {r8[3:0], v[11:8]}, '0, '0));
				end
			end
			FT_16: begin
				base = c * 2;
				send(make_req(FN_LOAD, base[15:0], v[7:0], '0, '0));
				send(make_req(FN_LOAD, base[15:0] + 16'd1, v[15:8], '0, '0));
			end
			default: begin
				base = c * 4;
				send(make_req(FN_LOAD, base[15:0], v[7:0], '0, '0));
				send(make_req(FN_LOAD, base[15:0] + 16'd1, v[15:8], '0, '0));
				send(make_req(FN_LOAD, base[15:0] + 16'd2, v[23:16], '0, '0));
				send(make_req(FN_LOAD, base[15:0] + 16'd3, {r8[3:0], v[27:24]}, '0, '0));
			end
		endcase
	endtask

	// builds a short chain of distinct clusters, then walks it
	task automatic chain_run(input logic [1:0] ft);
		logic [31:0] links [0:7];
		logic [31:0] mark;
		logic [31:0] tail;
		logic [31:0] c;
		logic [15:0] st;
		logic [2:0]  f;
		logic        clash;
		int          len;
		int          k;
		int          j;
		mark = end_marker(ft);
		len  = $urandom_range(1, 6);
		for (k = 0; k < len; k++) begin
			do begin
				case (ft)
					FT_12:   c = 2 * $urandom_range(0, 2047);
					FT_16:   c = $urandom_range(0, 32767);
					default: c = $urandom_range(0, 16383);
				endcase
				clash = 1'b0;
				for (j = 0; j < k; j++)
					if (links[j] == c)
						clash = 1'b1;
			end while (clash);
			links[k] = c;
		end
		for (k = 0; k < len - 1; k++)
			put_entry(ft, links[k], links[k+1]);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: tail = mark + $urandom_range(0, 7);
			6, 7: tail = links[$urandom_range(0, len - 1)];
			8: begin
				if (ft == FT_12)
					tail = $urandom_range(0, 4095);
				else if (ft == FT_16)
					tail = $urandom_range(32768, END16 - 1);
				else
					tail = $urandom_range(16384, END32 - 1);
			end
			default: tail = '0;
		endcase
		put_entry(ft, links[len-1], tail);
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 2))
				0:       f = FN_NEXT;
				1:       f = FN_FOLLOW;
				default: f = FN_LENGTH;
			endcase
			st = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, len + 2));
			c  = $urandom_range(0, 1) ? links[0] : links[$urandom_range(0, len - 1)];
			send(make_req(f, $urandom, $urandom, c, st));
		end
	endtask

	task automatic noise_item;
		logic [2:0]  f;
		logic [31:0] c;
		case ($urandom_range(0, 9))
			4:       f = FN_LAST - $urandom_range(0, 2);
			5:       f = FN_NEXT;
			6:       f = FN_FOLLOW;
			7:       f = FN_LENGTH;
			8:       f = FN_COUNT;
			default: f = FN_LOAD;
		endcase
		c = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4095);
		send(make_req(f, $urandom, $urandom, c, $urandom));
	endtask

	initial begin
		repeat (50_000_000) @(posedge clk);
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		int         a;
		int         seg;
		int         seg_start;
		int         fill_n;
		int         directed_n;
		int         others;
		logic [1:0] seg_ft;
		for (a = 0; a < 8; a++)
			by_func[a] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every byte written once so no read ever meets an unwritten one
		for (a = 0; a < TABLE_BYTES; a++)
			send(make_req(FN_LOAD, a[15:0], $urandom, $urandom, $urandom));
		fill_n = sent;

		idle_pct = 27;
		put_entry(FT_16, 32'd2, 32'd5);
		put_entry(FT_16, 32'd5, 32'd32767);
		put_entry(FT_16, 32'd32767, 32'hFFF9);
		send(make_req(FN_NEXT, '0, '0, 32'd2, '0));
		send(make_req(FN_FOLLOW, '0, '0, 32'd2, 16'd0));
		send(make_req(FN_FOLLOW, '0, '0, 32'd2, 16'hFFFF));
		send(make_req(FN_LENGTH, '0, '0, 32'd2, '0));
		send(make_req(FN_NEXT, '0, '0, 32'd32768, '0));
		send(make_req(FN_NEXT, '1, '1, 32'hFFFF_FFFF, '1));
		for (a = FN_COUNT + 1; a <= FN_LAST; a++)
			send(make_req(a[2:0], $urandom, $urandom, $urandom, $urandom));
		send(make_req(FN_COUNT, '0, '0, '0, '0));

		set_regs(FT_12, 16'd43690, 16'd0);
		send(make_req(FN_FOLLOW, '0, '0, 32'd2, 16'd1));
		send(make_req(FN_LENGTH, '0, '0, 32'd2, '0));
		send(make_req(FN_COUNT, '0, '0, '0, '0));

		set_regs(FT_12, 16'd0, 16'd1);
		send(make_req(FN_FOLLOW, '0, '0, 32'd2, 16'hFFFF));
		send(make_req(FN_COUNT, '0, '0, '0, '0));

		set_regs(FT_ALT, 16'hFFFF, 16'hFFFF);
		send(make_req(FN_COUNT, '0, '0, '0, '0));
		send(make_req(FN_NEXT, '0, '0, 32'd16383, '0));
		send(make_req(FN_NEXT, '0, '0, 32'd16384, '0));
		send(make_req(FN_FOLLOW, '0, '0, 32'd16383, 16'hFFFF));
		directed_n = sent - fill_n;

		for (seg = 0; seg < 6; seg++) begin
			seg_ft = seg[1:0];
			set_regs(seg_ft, $urandom_range(0, 1500),
				(seg == 1) ? $urandom_range(1, 4) : $urandom_range(1, 200));
			idle_pct  = (seg < 2) ? 27 : (seg < 4) ? 87 : 0;
			seg_start = sent;
			while (sent - seg_start < 67) begin
				if ($urandom_range(0, 3) == 0)
					noise_item();
				else
					chain_run(seg_ft);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		others = 0;
		for (a = FN_COUNT + 1; a <= FN_LAST; a++)
			others += by_func[a];
		$display("tb: %0d table bytes filled, then %0d directed and %0d random items, %0d results compared",
			fill_n, directed_n, sent - fill_n - directed_n, checked);
		$display("tb: loads %0d, lookups %0d, follows %0d, lengths %0d, counts %0d, unused codes %0d",
			by_func[FN_LOAD], by_func[FN_NEXT], by_func[FN_FOLLOW], by_func[FN_LENGTH],
			by_func[FN_COUNT], others);
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
